>>> hdl/iff_pkg.sv
// ----------------------------------------------------------------------------
// Integer field formatter package
// Shared widths, character codes, command and status structs and the digit table.
// ----------------------------------------------------------------------------
package iff_pkg;

    localparam int MAX_FIELD_DEF = 63;

    localparam int VALUE_W    = 32;
    localparam int WIDTH_W    = 6;
    localparam int PREC_W     = 7;
    localparam int CHAR_W     = 8;
    localparam int COUNT_W    = 7;
    localparam int S_TDATA_W  = 48;
    localparam int M_TDATA_W  = 16;

    localparam int DEC_DIGITS = 10;
    localparam int DIGIT_W    = 4;
    localparam int BCD_W      = DEC_DIGITS * DIGIT_W;
    localparam int DD_BITS    = 4;
    localparam int DD_STEPS   = VALUE_W / DD_BITS;
    localparam int DD_CNT_W   = $clog2(DD_STEPS);

    localparam logic REQ_DEC = 1'b0;
    localparam logic REQ_HEX = 1'b1;

    localparam logic [CHAR_W-1:0] CHAR_NUL   = 8'h00;
    localparam logic [CHAR_W-1:0] CHAR_SPACE = 8'h20;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'h2D;
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'h30;

    typedef struct packed {
        logic load;
        logic conv;
        logic size;
        logic emit;
    } iff_cmd_t;

    typedef struct packed {
        logic is_hex;
        logic out_free;
        logic emit_last;
    } iff_status_t;

    // Lower-case hexadecimal digit table; decimal digits use its first ten entries.
    function automatic logic [CHAR_W-1:0] digit_char(input logic [DIGIT_W-1:0] d);
        logic [CHAR_W-1:0] c;
        unique case (d)
            4'h0: c = 8'h30;
            4'h1: c = 8'h31;
            4'h2: c = 8'h32;
            4'h3: c = 8'h33;
            4'h4: c = 8'h34;
            4'h5: c = 8'h35;
            4'h6: c = 8'h36;
            4'h7: c = 8'h37;
            4'h8: c = 8'h38;
            4'h9: c = 8'h39;
            4'ha: c = 8'h61;
            4'hb: c = 8'h62;
            4'hc: c = 8'h63;
            4'hd: c = 8'h64;
            4'he: c = 8'h65;
            4'hf: c = 8'h66;
        endcase
        return c;
    endfunction

endpackage

>>> hdl/iff_ctrl.sv
// ----------------------------------------------------------------------------
// Integer field formatter controller
// Sequences load, digit conversion, sizing and character emission.
// ----------------------------------------------------------------------------
module iff_ctrl (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  iff_pkg::iff_status_t status,
    output iff_pkg::iff_cmd_t    cmd
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SIZE,
        ST_EMIT
    } state_t;

    state_t                        state_reg;
    logic [iff_pkg::DD_CNT_W-1:0]  step_cnt_reg;

    always_comb begin
        cmd      = '0;
        s_tready = (state_reg == ST_IDLE);
        unique case (state_reg)
            ST_IDLE: cmd.load = s_tvalid;
            ST_CONV: cmd.conv = !status.is_hex;
            ST_SIZE: cmd.size = 1'b1;
            ST_EMIT: cmd.emit = status.out_free;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            step_cnt_reg <= '0;
        end else begin
            unique case (state_reg)
                ST_IDLE: begin
                    step_cnt_reg <= '0;
                    if (s_tvalid) begin
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    // Hex values need no conversion; the nibbles are the digits.
                    if (status.is_hex) begin
                        state_reg <= ST_SIZE;
                    end else begin
                        step_cnt_reg <= step_cnt_reg + 1'b1;
                        if (step_cnt_reg == iff_pkg::DD_CNT_W'(iff_pkg::DD_STEPS - 1)) begin
                            state_reg <= ST_SIZE;
                        end
                    end
                end
                ST_SIZE: state_reg <= ST_EMIT;
                ST_EMIT: begin
                    if (status.out_free && status.emit_last) begin
                        state_reg <= ST_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

>>> hdl/iff_datapath.sv
// ----------------------------------------------------------------------------
// Integer field formatter datapath
// Request registers, binary-to-BCD shifter, field sizing and output register.
// ----------------------------------------------------------------------------
module iff_datapath #(
    parameter int MAX_FIELD = iff_pkg::MAX_FIELD_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  iff_pkg::iff_cmd_t               cmd,
    output iff_pkg::iff_status_t            status,
    input  logic [iff_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic                            s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [iff_pkg::M_TDATA_W-1:0]   m_tdata,
    output logic                            m_tuser,
    output logic                            m_tlast
);

    localparam int VW = iff_pkg::VALUE_W;
    localparam int WW = iff_pkg::WIDTH_W;
    localparam int PW = iff_pkg::PREC_W;
    localparam int CW = iff_pkg::COUNT_W;
    localparam int BW = iff_pkg::BCD_W;
    localparam int DW = iff_pkg::DIGIT_W;
    localparam logic [8:0] MAX_F = 9'(MAX_FIELD);

    // Request registers
    logic           hex_reg;
    logic           neg_reg;
    logic           hasp_reg;
    logic [WW-1:0]  prec_reg;
    logic [WW-1:0]  width_reg;
    logic [VW-1:0]  bin_reg;
    logic [BW-1:0]  bcd_reg;

    // Field layout registers
    logic [DW-1:0]  nd_reg;
    logic [CW-1:0]  pad_reg;
    logic [CW-1:0]  zend_reg;
    logic [CW-1:0]  total_reg;
    logic [CW-1:0]  k_reg;

    // Output register
    logic                            m_tvalid_reg;
    logic [iff_pkg::CHAR_W-1:0]      m_char_reg;
    logic [CW-1:0]                   m_count_reg;
    logic                            m_last_reg;
    logic                            m_empty_reg;

    // Load decode
    logic [VW-1:0]  in_value;
    logic [WW-1:0]  in_width;
    logic [PW-1:0]  in_prec;
    logic           in_neg;
    logic [VW-1:0]  in_mag;
    logic [WW-1:0]  width_sat;
    logic [WW-1:0]  prec_sat;

    // Sizing and emission
    logic [DW-1:0]              nd_c;
    logic [WW-1:0]              zeros_c;
    logic [CW-1:0]              body_c;
    logic [CW-1:0]              pad_c;
    logic [CW-1:0]              total_c;
    logic                       last_c;
    logic                       empty_c;
    logic [CW-1:0]              idx_c;
    logic [DW-1:0]              nib_c;
    logic [iff_pkg::CHAR_W-1:0] char_c;

    // Double-dabble: DD_BITS shifts per call, each with add-3 on every digit of 5 or more.
    function automatic logic [BW+VW-1:0] dd_step(input logic [BW-1:0] bcd,
                                                 input logic [VW-1:0] bin);
        logic [BW-1:0] b;
        logic [VW-1:0] r;
        b = bcd;
        r = bin;
        for (int s = 0; s < iff_pkg::DD_BITS; s++) begin
            for (int i = 0; i < iff_pkg::DEC_DIGITS; i++) begin
                if (b[i*DW +: DW] >= 4'd5) begin
                    b[i*DW +: DW] = b[i*DW +: DW] + 4'd3;
                end
            end
            b = {b[BW-2:0], r[VW-1]};
            r = {r[VW-2:0], 1'b0};
        end
        return {b, r};
    endfunction

    always_comb begin
        in_value = s_tdata[VW-1:0];
        in_width = s_tdata[VW +: WW];
        in_prec  = s_tdata[VW+WW +: PW];
        in_neg   = (s_tuser == iff_pkg::REQ_DEC) && in_value[VW-1];
        in_mag   = in_neg ? (~in_value + 1'b1) : in_value;
        width_sat = ({3'b000, in_width} > MAX_F) ? MAX_F[WW-1:0] : in_width;
        prec_sat  = ({3'b000, in_prec[WW-1:0]} > MAX_F) ? MAX_F[WW-1:0] : in_prec[WW-1:0];
    end

    always_comb begin
        nd_c = 4'd1;
        for (int i = 1; i < iff_pkg::DEC_DIGITS; i++) begin
            if (bcd_reg[i*DW +: DW] != '0) begin
                nd_c = DW'(i + 1);
            end
        end
        // A zero value with an explicit precision prints no digits.
        if (bcd_reg == '0 && hasp_reg) begin
            nd_c = '0;
        end
        if (hasp_reg && (prec_reg > {2'b00, nd_c})) begin
            zeros_c = prec_reg - {2'b00, nd_c};
        end else begin
            zeros_c = '0;
        end
        body_c = {3'b000, nd_c} + {1'b0, zeros_c} + {6'b0, neg_reg};
        if ({1'b0, width_reg} > body_c) begin
            pad_c = {1'b0, width_reg} - body_c;
        end else begin
            pad_c = '0;
        end
        total_c = pad_c + body_c;
    end

    always_comb begin
        empty_c = (total_reg == '0);
        last_c  = empty_c || (k_reg == total_reg - 1'b1);
        // Digits fill the tail of the field, most significant first.
        idx_c   = total_reg - 1'b1 - k_reg;
        nib_c   = '0;
        for (int i = 0; i < iff_pkg::DEC_DIGITS; i++) begin
            if (idx_c[DW-1:0] == DW'(i)) begin
                nib_c = bcd_reg[i*DW +: DW];
            end
        end
        priority if (empty_c) begin
            char_c = iff_pkg::CHAR_NUL;
        end else if (k_reg < pad_reg) begin
            char_c = iff_pkg::CHAR_SPACE;
        end else if (neg_reg && (k_reg == pad_reg)) begin
            char_c = iff_pkg::CHAR_MINUS;
        end else if (k_reg < zend_reg) begin
            char_c = iff_pkg::CHAR_ZERO;
        end else begin
            char_c = iff_pkg::digit_char(nib_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            hex_reg   <= (s_tuser == iff_pkg::REQ_HEX);
            neg_reg   <= in_neg;
            hasp_reg  <= !in_prec[PW-1];
            prec_reg  <= prec_sat;
            width_reg <= width_sat;
            bin_reg   <= in_mag;
            bcd_reg   <= (s_tuser == iff_pkg::REQ_HEX) ? {{(BW-VW){1'b0}}, in_mag} : '0;
        end else if (cmd.conv) begin
            {bcd_reg, bin_reg} <= dd_step(bcd_reg, bin_reg);
        end
        if (cmd.size) begin
            nd_reg    <= nd_c;
            pad_reg   <= pad_c;
            zend_reg  <= total_c - {3'b000, nd_c};
            total_reg <= total_c;
            k_reg     <= '0;
        end else if (cmd.emit) begin
            k_reg <= k_reg + 1'b1;
        end
        if (cmd.emit) begin
            m_char_reg  <= char_c;
            m_last_reg  <= last_c;
            m_empty_reg <= empty_c;
            m_count_reg <= last_c ? total_reg : '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (cmd.emit) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    assign status.is_hex    = hex_reg;
    assign status.out_free  = !m_tvalid_reg || m_tready;
    assign status.emit_last = last_c && (nd_reg <= 4'd10);

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {1'b0, m_count_reg, m_char_reg};
    assign m_tuser  = m_empty_reg;
    assign m_tlast  = m_last_reg;

endmodule

>>> hdl/integer_field_formatter.sv
// ----------------------------------------------------------------------------
// Integer field formatter
// One printf-style integer conversion (%d or %x with width and precision).
// ----------------------------------------------------------------------------
// Each input transaction is one conversion request; the block answers with
// one output transaction per ASCII character, in the order left padding
// spaces, a minus sign for a negative decimal, zero fill up to the
// precision, then the digits most significant first. The final character
// has tlast set and carries the total character count; when nothing is
// printed a single empty marker (tuser set, character and count zero) is
// sent instead. Requests are handled one at a time: an accepted request
// is loaded, run through the binary-to-decimal shifter (four bits per
// cycle) if it is decimal or passed straight on if it is hex, sized, and
// then emitted character by character through the output register, which
// takes a new character whenever it is empty or its character is being
// taken. The next request is taken once the last character is in the
// output register, even while that character waits to be taken.
// Width and precision above MAX_FIELD are saturated to it.
// ----------------------------------------------------------------------------
module integer_field_formatter #(
    parameter int MAX_FIELD = iff_pkg::MAX_FIELD_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // Request channel.
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // s_tdata: value_bits [31:0], field_width [37:32], precision [44:38], zero fill.
    input  logic [iff_pkg::S_TDATA_W-1:0]   s_tdata,
    // s_tuser: req_type (0 signed decimal, 1 lower-case hex).
    input  logic                            s_tuser,
    // Character channel.
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // m_tdata: out_char [7:0], total_count [14:8], zero fill.
    output logic [iff_pkg::M_TDATA_W-1:0]   m_tdata,
    // m_tuser: empty_res.
    output logic                            m_tuser,
    // m_tlast: last character of the conversion.
    output logic                            m_tlast
);

    // Commands from the controller and status back from the datapath.
    iff_pkg::iff_cmd_t    cmd;
    iff_pkg::iff_status_t status;

    iff_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    iff_datapath #(
        .MAX_FIELD (MAX_FIELD)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

endmodule

>>> hdl/iff_checker.sv
// ----------------------------------------------------------------------------
// Integer field formatter checker
// Port-level properties of the formatter, bound to the top level.
// ----------------------------------------------------------------------------
module iff_checker (
    input logic                            aclk,
    input logic                            aresetn,
    input logic                            s_tvalid,
    input logic                            s_tready,
    input logic                            m_tvalid,
    input logic                            m_tready,
    input logic [iff_pkg::M_TDATA_W-1:0]   m_tdata,
    input logic                            m_tuser,
    input logic                            m_tlast
);

    // A stalled character holds its contents.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("stalled output transaction changed");

    // The empty marker ends its conversion and carries no character or count.
    a_empty_form: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast && (m_tdata == '0))
        else $error("malformed empty marker");

    // Only the last character carries a count, and a printed one is never zero.
    a_count_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast ? (m_tuser || (m_tdata[14:8] != '0)) : (m_tdata[14:8] == '0)))
        else $error("total count on the wrong character");

    // Requests are taken one at a time.
    a_one_request: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("request accepted while a conversion is running");

endmodule

bind integer_field_formatter iff_checker u_iff_checker (.*);
